// File: hw/rtl/uerm_pkg.sv
// uerm_pkg: types and constants for the ultrasonic echo range meter
// request and result structs, phase enum, register indexes, reset values
// no dependencies
package uerm_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TRIG_LOW,
    PH_TRIG_HIGH,
    PH_WAIT_RISE,
    PH_MEASURE,
    PH_DIVIDE
  } phase_t;

  typedef enum logic [1:0] {
    REG_TICKS_PER_US     = 2'd0,
    REG_START_TIMEOUT_US = 2'd1,
    REG_ECHO_TIMEOUT_US  = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic       start_req;
    logic [1:0] sensor_index;
    logic [3:0] echo_levels;
  } in_t;

  typedef struct packed {
    logic [3:0]  trigger_lines;
    logic        busy_res;
    logic        done_res;
    logic        success;
    logic [12:0] measured_distance;
    logic [12:0] latest_distance;
  } out_t;

  localparam int unsigned TRIG_LOW_US   = 2;
  localparam int unsigned TRIG_HIGH_US  = 10;
  localparam int unsigned CM_DIVISOR    = 58;
  localparam int unsigned RANGE_LO_MULT = 116;
  localparam int unsigned RANGE_HI_MULT = 23200;
  localparam int unsigned QUOT_MSB      = 12;
  localparam int unsigned MAX_DISTANCE  = 6400;

  localparam logic [7:0]  TPU_RESET           = 8'd168;
  localparam logic [15:0] START_TIMEOUT_RESET = 16'd2000;
  localparam logic [15:0] ECHO_TIMEOUT_RESET  = 16'd25000;

endpackage

// File: hw/rtl/ultrasonic_echo_range_meter.sv
// ultrasonic_echo_range_meter: trigger/echo timing with an iterative divider
// depends on uerm_pkg (request/result structs, phase enum, constants)
//
//   channel | dir | payload                  | accept
//   in      | in  | uerm_pkg::in_t  in_data  | in_valid && in_ready
//   out     | out | uerm_pkg::out_t out_data | out_valid && out_ready
//   cfg     | in  | cfg_index, cfg_data      | cfg_valid && cfg_ready
//
// every request is one timing tick and yields one result, registered in the cycle after it is taken
// the distance comes from a shared compare/subtract unit, one quotient bit per
// request, 13 requests after the echo falls
// a new request is taken while the result register is empty or being drained
// rst clears the phase, counters, divider, result valid flag and the per-sensor distances
// cfg_ready is always high; products of the timing registers are formed on write
module ultrasonic_echo_range_meter #(
  parameter int SENSORS = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  uerm_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output uerm_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_data
);

  logic [7:0]  tpu;
  logic [15:0] start_to;
  logic [15:0] echo_to;
  logic [23:0] start_lim;
  logic [23:0] echo_lim;
  logic [8:0]  tl_lim;
  logic [11:0] th_lim;
  logic [14:0] lo_lim;
  logic [22:0] hi_lim;
  logic [13:0] divisor;

  uerm_pkg::phase_t phase, phase_next;
  logic [23:0] tick_count, tick_count_next;
  logic [1:0]  active_sensor, active_sensor_next;
  logic [27:0] divide_remainder, divide_remainder_next;
  logic [12:0] divide_quotient, divide_quotient_next;
  logic [12:0] stored_distance [SENSORS];
  logic [12:0] stored_distance_next [SENSORS];

  logic        accept;
  logic        done, ok, store_we, level;
  logic [12:0] meas_dist, latest;
  logic [24:0] tick_inc;
  logic [3:0]  bit_pos;
  logic [27:0] shifted;
  logic [27:0] diff;
  logic        rem_ge;
  uerm_pkg::out_t result;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tpu       <= uerm_pkg::TPU_RESET;
      start_to  <= uerm_pkg::START_TIMEOUT_RESET;
      echo_to   <= uerm_pkg::ECHO_TIMEOUT_RESET;
      start_lim <= 24'(32'(uerm_pkg::START_TIMEOUT_RESET) * 32'(uerm_pkg::TPU_RESET));
      echo_lim  <= 24'(32'(uerm_pkg::ECHO_TIMEOUT_RESET) * 32'(uerm_pkg::TPU_RESET));
      tl_lim    <= 9'(uerm_pkg::TRIG_LOW_US * 32'(uerm_pkg::TPU_RESET));
      th_lim    <= 12'(uerm_pkg::TRIG_HIGH_US * 32'(uerm_pkg::TPU_RESET));
      lo_lim    <= 15'(uerm_pkg::RANGE_LO_MULT * 32'(uerm_pkg::TPU_RESET));
      hi_lim    <= 23'(uerm_pkg::RANGE_HI_MULT * 32'(uerm_pkg::TPU_RESET));
      divisor   <= 14'(uerm_pkg::CM_DIVISOR * 32'(uerm_pkg::TPU_RESET));
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        uerm_pkg::REG_TICKS_PER_US: begin
          tpu       <= cfg_data[7:0];
          start_lim <= 24'(start_to) * 24'(cfg_data[7:0]);
          echo_lim  <= 24'(echo_to) * 24'(cfg_data[7:0]);
          tl_lim    <= 9'(uerm_pkg::TRIG_LOW_US * 32'(cfg_data[7:0]));
          th_lim    <= 12'(uerm_pkg::TRIG_HIGH_US * 32'(cfg_data[7:0]));
          lo_lim    <= 15'(uerm_pkg::RANGE_LO_MULT * 32'(cfg_data[7:0]));
          hi_lim    <= 23'(uerm_pkg::RANGE_HI_MULT * 32'(cfg_data[7:0]));
          divisor   <= 14'(uerm_pkg::CM_DIVISOR * 32'(cfg_data[7:0]));
        end
        uerm_pkg::REG_START_TIMEOUT_US: begin
          start_to  <= cfg_data;
          start_lim <= 24'(cfg_data) * 24'(tpu);
        end
        uerm_pkg::REG_ECHO_TIMEOUT_US: begin
          echo_to  <= cfg_data;
          echo_lim <= 24'(cfg_data) * 24'(tpu);
        end
        default: begin
        end
      endcase
    end
  end

  // shared compare/subtract unit of the restoring divider
  assign bit_pos = (tick_count[3:0] > 4'(uerm_pkg::QUOT_MSB)) ?
                   4'(uerm_pkg::QUOT_MSB) : tick_count[3:0];
  assign shifted = 28'(divisor) << bit_pos;
  assign rem_ge  = divide_remainder >= shifted;
  assign diff    = divide_remainder - shifted;

  assign tick_inc = 25'(tick_count) + 25'd1;
  assign level    = in_data.echo_levels[active_sensor];

  always_comb begin
    phase_next            = phase;
    tick_count_next       = tick_count;
    active_sensor_next    = active_sensor;
    divide_remainder_next = divide_remainder;
    divide_quotient_next  = divide_quotient;
    done                  = 1'b0;
    ok                    = 1'b0;
    meas_dist             = '0;
    store_we              = 1'b0;
    unique case (phase)
      uerm_pkg::PH_IDLE: begin
        if (in_data.start_req) begin
          active_sensor_next = in_data.sensor_index;
          if (32'(in_data.sensor_index) >= SENSORS) begin
            done = 1'b1;
          end else begin
            phase_next      = uerm_pkg::PH_TRIG_LOW;
            tick_count_next = '0;
          end
        end
      end
      uerm_pkg::PH_TRIG_LOW: begin
        tick_count_next = tick_inc[23:0];
        if (tick_inc >= 25'(tl_lim)) begin
          phase_next      = uerm_pkg::PH_TRIG_HIGH;
          tick_count_next = '0;
        end
      end
      uerm_pkg::PH_TRIG_HIGH: begin
        tick_count_next = tick_inc[23:0];
        if (tick_inc >= 25'(th_lim)) begin
          phase_next      = uerm_pkg::PH_WAIT_RISE;
          tick_count_next = '0;
        end
      end
      uerm_pkg::PH_WAIT_RISE: begin
        if (level) begin
          phase_next      = uerm_pkg::PH_MEASURE;
          tick_count_next = 24'd1;
        end else begin
          tick_count_next = tick_inc[23:0];
          if (tick_inc > 25'(start_lim)) begin
            phase_next = uerm_pkg::PH_IDLE;
            done       = 1'b1;
          end
        end
      end
      uerm_pkg::PH_MEASURE: begin
        if (!level) begin
          if (tick_count >= 24'(lo_lim) && tick_count <= 24'(hi_lim)) begin
            divide_remainder_next = {tick_count, 4'b0000};
            divide_quotient_next  = '0;
            tick_count_next       = 24'(uerm_pkg::QUOT_MSB);
            phase_next            = uerm_pkg::PH_DIVIDE;
          end else begin
            phase_next = uerm_pkg::PH_IDLE;
            done       = 1'b1;
          end
        end else begin
          tick_count_next = tick_inc[23:0];
          if (tick_inc > 25'(echo_lim)) begin
            phase_next = uerm_pkg::PH_IDLE;
            done       = 1'b1;
          end
        end
      end
      uerm_pkg::PH_DIVIDE: begin
        if (rem_ge) begin
          divide_remainder_next = diff;
          divide_quotient_next  = divide_quotient | (13'd1 << bit_pos);
        end
        if (bit_pos == 4'd0) begin
          store_we   = 1'b1;
          phase_next = uerm_pkg::PH_IDLE;
          done       = 1'b1;
          ok         = 1'b1;
          meas_dist  = divide_quotient_next;
        end else begin
          tick_count_next = 24'(bit_pos - 4'd1);
        end
      end
      default: begin
        phase_next = uerm_pkg::PH_IDLE;
      end
    endcase
  end

  always_comb begin
    latest = '0;
    for (int i = 0; i < SENSORS; i++) begin
      stored_distance_next[i] = stored_distance[i];
      if (store_we && 32'(active_sensor) == i) begin
        stored_distance_next[i] = divide_quotient_next;
      end
      if (32'(in_data.sensor_index) == i) begin
        latest = stored_distance_next[i];
      end
    end
  end

  always_comb begin
    result.trigger_lines     = (phase_next == uerm_pkg::PH_TRIG_HIGH) ?
                               (4'd1 << active_sensor_next) : 4'd0;
    result.busy_res          = phase_next != uerm_pkg::PH_IDLE;
    result.done_res          = done;
    result.success           = ok;
    result.measured_distance = meas_dist;
    result.latest_distance   = latest;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= uerm_pkg::PH_IDLE;
      tick_count    <= '0;
      active_sensor <= '0;
      out_valid     <= 1'b0;
      for (int i = 0; i < SENSORS; i++) begin
        stored_distance[i] <= '0;
      end
    end else begin
      if (accept) begin
        phase         <= phase_next;
        tick_count    <= tick_count_next;
        active_sensor <= active_sensor_next;
        for (int i = 0; i < SENSORS; i++) begin
          stored_distance[i] <= stored_distance_next[i];
        end
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      divide_remainder <= '0;
      divide_quotient  <= '0;
    end else if (accept) begin
      divide_remainder <= divide_remainder_next;
      divide_quotient  <= divide_quotient_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while result stalled");

  a_divide_bit: assert property (@(posedge clk) disable iff (rst)
    phase == uerm_pkg::PH_DIVIDE |-> tick_count <= 24'(uerm_pkg::QUOT_MSB))
    else $error("divider bit position out of range");

  a_divide_ends: assert property (@(posedge clk) disable iff (rst)
    accept && phase == uerm_pkg::PH_DIVIDE && tick_count == 24'd0
    |=> phase == uerm_pkg::PH_IDLE && out_data.success)
    else $error("last divider step did not finish the measurement");

  a_success_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.success |->
    out_data.done_res && out_data.measured_distance <= 13'(uerm_pkg::MAX_DISTANCE))
    else $error("success without done or distance out of range");

  a_trigger_phase: assert property (@(posedge clk) disable iff (rst)
    accept |=> (out_data.trigger_lines != 4'd0) == (phase == uerm_pkg::PH_TRIG_HIGH))
    else $error("trigger drive does not follow the pulse phase");

endmodule

// File: tb/tb_ultrasonic_echo_range_meter.sv
// tb_ultrasonic_echo_range_meter: self-checking bench for the echo range meter
// feeds timing ticks as requests, predicts every result and compares field by field
// depends on uerm_pkg and ultrasonic_echo_range_meter
module tb_ultrasonic_echo_range_meter;

  localparam int unsigned NUM_SENSORS   = 4;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned CYCLE_LIMIT   = 100000;
  localparam int unsigned RANDOM_TICKS  = 850;
  localparam int unsigned MIN_EPISODES  = 6;
  localparam int unsigned IDLE_PCT      = 38;
  localparam int unsigned HOLD_CYCLES   = 96;

  typedef struct packed {
    uerm_pkg::reg_index_t idx;
    logic [15:0]          data;
  } reg_write_t;

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           in_valid  = 1'b0;
  logic           in_ready;
  uerm_pkg::in_t  in_data   = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  uerm_pkg::out_t out_data;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [1:0]     cfg_index = '0;
  logic [15:0]    cfg_data  = '0;

  uerm_pkg::in_t  echo_ticks[$];
  uerm_pkg::out_t predicted[$];
  reg_write_t     reg_writes[$];
  int unsigned ticks_queued  = 0;
  int unsigned readings_seen = 0;
  int unsigned cfg_queued    = 0;
  int unsigned cfg_done      = 0;
  int unsigned fail_count    = 0;
  int unsigned cycle_count   = 0;
  int unsigned hold_left     = 0;
  bit          steady        = 1'b0;

  // predicted sensor timing state and timing registers
  uerm_pkg::phase_t meas_phase = uerm_pkg::PH_IDLE;
  logic [23:0] tick_cnt   = '0;
  logic [1:0]  act_sensor = '0;
  logic [27:0] div_rem    = '0;
  logic [12:0] div_quot   = '0;
  logic [12:0] dist_store [NUM_SENSORS] = '{default: '0};
  logic [7:0]  tpu_r      = uerm_pkg::TPU_RESET;
  logic [15:0] start_to_r = uerm_pkg::START_TIMEOUT_RESET;
  logic [15:0] echo_to_r  = uerm_pkg::ECHO_TIMEOUT_RESET;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ultrasonic_echo_range_meter #(.SENSORS(NUM_SENSORS)) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic void step_ranging(input uerm_pkg::in_t req, output uerm_pkg::out_t res);
    logic        level;
    logic        done;
    logic        ok;
    logic [12:0] meas_dist;
    int unsigned tick;
    int unsigned bitn;
    int unsigned divisor;
    int unsigned shifted;
    level     = req.echo_levels[act_sensor];
    done      = 1'b0;
    ok        = 1'b0;
    meas_dist = '0;
    divisor   = uerm_pkg::CM_DIVISOR * tpu_r;
    tick      = tick_cnt;
    case (meas_phase)
      uerm_pkg::PH_IDLE: begin
        if (req.start_req) begin
          act_sensor = req.sensor_index;
          if (32'(req.sensor_index) >= NUM_SENSORS) begin
            done = 1'b1;
          end else begin
            meas_phase = uerm_pkg::PH_TRIG_LOW;
            tick = 0;
          end
        end
      end
      uerm_pkg::PH_TRIG_LOW: begin
        tick++;
        if (tick >= uerm_pkg::TRIG_LOW_US * tpu_r) begin
          meas_phase = uerm_pkg::PH_TRIG_HIGH;
          tick = 0;
        end
      end
      uerm_pkg::PH_TRIG_HIGH: begin
        tick++;
        if (tick >= uerm_pkg::TRIG_HIGH_US * tpu_r) begin
          meas_phase = uerm_pkg::PH_WAIT_RISE;
          tick = 0;
        end
      end
      uerm_pkg::PH_WAIT_RISE: begin
        if (level) begin
          meas_phase = uerm_pkg::PH_MEASURE;
          tick = 1;
        end else begin
          tick++;
          if (tick > start_to_r * tpu_r) begin
            meas_phase = uerm_pkg::PH_IDLE;
            done = 1'b1;
          end
        end
      end
      uerm_pkg::PH_MEASURE: begin
        if (!level) begin
          if (tick >= uerm_pkg::RANGE_LO_MULT * tpu_r &&
              tick <= uerm_pkg::RANGE_HI_MULT * tpu_r) begin
            div_rem    = {tick[23:0], 4'b0000};
            div_quot   = '0;
            tick       = uerm_pkg::QUOT_MSB;
            meas_phase = uerm_pkg::PH_DIVIDE;
          end else begin
            meas_phase = uerm_pkg::PH_IDLE;
            done = 1'b1;
          end
        end else begin
          tick++;
          if (tick > echo_to_r * tpu_r) begin
            meas_phase = uerm_pkg::PH_IDLE;
            done = 1'b1;
          end
        end
      end
      uerm_pkg::PH_DIVIDE: begin
        bitn = tick & 15;
        if (bitn > uerm_pkg::QUOT_MSB) bitn = uerm_pkg::QUOT_MSB;
        shifted = divisor << bitn;
        if ({4'b0000, div_rem} >= shifted) begin
          div_rem = div_rem - shifted[27:0];
          div_quot[bitn] = 1'b1;
        end
        if (bitn == 0) begin
          dist_store[act_sensor] = div_quot;
          meas_phase = uerm_pkg::PH_IDLE;
          done = 1'b1;
          ok   = 1'b1;
          meas_dist = div_quot;
        end else begin
          tick = bitn - 1;
        end
      end
      default: meas_phase = uerm_pkg::PH_IDLE;
    endcase
    tick_cnt = tick[23:0];
    res.trigger_lines     = (meas_phase == uerm_pkg::PH_TRIG_HIGH) ?
                            (4'b0001 << act_sensor) : 4'b0000;
    res.busy_res          = (meas_phase != uerm_pkg::PH_IDLE);
    res.done_res          = done;
    res.success           = ok;
    res.measured_distance = meas_dist;
    res.latest_distance   = (32'(req.sensor_index) < NUM_SENSORS) ?
                            dist_store[req.sensor_index] : 13'd0;
  endfunction

  // request side
  always @(posedge clk) begin
    uerm_pkg::out_t res;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        step_ranging(in_data, res);
        predicted.push_back(res);
      end
      if (!in_valid || in_ready) begin
        if (echo_ticks.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          in_data  <= echo_ticks.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    uerm_pkg::out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        readings_seen++;
        if (predicted.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("cycle %0d: result with no request pending: %h", cycle_count, out_data);
        end else begin
          want = predicted.pop_front();
          if (out_data.trigger_lines !== want.trigger_lines ||
              out_data.busy_res !== want.busy_res ||
              out_data.done_res !== want.done_res ||
              out_data.success !== want.success ||
              out_data.measured_distance !== want.measured_distance ||
              out_data.latest_distance !== want.latest_distance) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"cycle %0d: expected trig=%h busy=%b done=%b ok=%b dist=%0d ",
                        "latest=%0d, got trig=%h busy=%b done=%b ok=%b dist=%0d latest=%0d"},
                       cycle_count, want.trigger_lines, want.busy_res, want.done_res,
                       want.success, want.measured_distance, want.latest_distance,
                       out_data.trigger_lines, out_data.busy_res, out_data.done_res,
                       out_data.success, out_data.measured_distance,
                       out_data.latest_distance);
          end
        end
      end
      out_ready <= (hold_left == 0) && (steady || $urandom_range(99) >= IDLE_PCT);
    end
  end

  // receiver hold-off so the block backs up into the request channel
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (cycle_count % 2048 == 400) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    reg_write_t w;
    if (rst) begin
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (uerm_pkg::reg_index_t'(cfg_index))
          uerm_pkg::REG_TICKS_PER_US:     tpu_r = cfg_data[7:0];
          uerm_pkg::REG_START_TIMEOUT_US: start_to_r = cfg_data;
          uerm_pkg::REG_ECHO_TIMEOUT_US:  echo_to_r = cfg_data;
          default: ;
        endcase
        cfg_done++;
      end
      if (!cfg_valid || cfg_ready) begin
        if (reg_writes.size() != 0) begin
          w = reg_writes.pop_front();
          cfg_index <= w.idx;
          cfg_data  <= w.data;
          cfg_valid <= 1'b1;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic push_tick(input logic start, input logic [1:0] sel, input logic [3:0] echo);
    uerm_pkg::in_t req;
    req.start_req    = start;
    req.sensor_index = sel;
    req.echo_levels  = echo;
    echo_ticks.push_back(req);
    ticks_queued++;
  endtask

  // start, trigger pulse, echo wait, echo high, then time for the divider
  task automatic queue_measurement(input logic [1:0] sensor, input int unsigned wait_ticks,
                                   input int unsigned high_ticks);
    int unsigned trig_ticks;
    logic [3:0]  lvl;
    trig_ticks = (tpu_r == 0) ? 2 :
                 (uerm_pkg::TRIG_LOW_US + uerm_pkg::TRIG_HIGH_US) * tpu_r;
    push_tick(1'b1, sensor, 4'($urandom_range(15)));
    repeat (trig_ticks)
      push_tick(1'($urandom_range(1)), 2'($urandom_range(3)), 4'($urandom_range(15)));
    repeat (wait_ticks) begin
      lvl = 4'($urandom_range(15));
      lvl[sensor] = 1'b0;
      push_tick(1'b0, 2'($urandom_range(3)), lvl);
    end
    repeat (high_ticks) begin
      lvl = 4'($urandom_range(15));
      lvl[sensor] = 1'b1;
      push_tick(1'b0, 2'($urandom_range(3)), lvl);
    end
    repeat (uerm_pkg::QUOT_MSB + 2) begin
      lvl = 4'($urandom_range(15));
      lvl[sensor] = 1'b0;
      push_tick(1'b0, 2'($urandom_range(3)), lvl);
    end
  endtask

  // start a measurement and leave it in its trigger pulse
  task automatic queue_partial(input logic [1:0] sensor, input int unsigned ticks);
    push_tick(1'b1, sensor, 4'($urandom_range(15)));
    repeat (ticks)
      push_tick(1'($urandom_range(1)), 2'($urandom_range(3)), 4'($urandom_range(15)));
  endtask

  // wait until every queued request has its result
  task automatic drain();
    while (readings_seen < ticks_queued) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // drain all results and run the block back to idle
  task automatic settle();
    bit still_busy;
    still_busy = 1'b1;
    while (still_busy) begin
      while (readings_seen < ticks_queued) @(posedge clk);
      still_busy = (meas_phase != uerm_pkg::PH_IDLE);
      if (still_busy)
        push_tick(1'b0, 2'($urandom_range(3)),
                  (meas_phase == uerm_pkg::PH_WAIT_RISE) ? 4'hF : 4'h0);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register writes; waits until all three are taken
  task automatic write_timing(input logic [7:0] tpu, input logic [15:0] st,
                              input logic [15:0] et);
    reg_writes.push_back('{idx: uerm_pkg::REG_TICKS_PER_US, data: {8'd0, tpu}});
    reg_writes.push_back('{idx: uerm_pkg::REG_START_TIMEOUT_US, data: st});
    reg_writes.push_back('{idx: uerm_pkg::REG_ECHO_TIMEOUT_US, data: et});
    cfg_queued += 3;
    while (cfg_done < cfg_queued) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_timing(input logic [7:0] tpu, input logic [15:0] st,
                            input logic [15:0] et);
    settle();
    write_timing(tpu, st, et);
  endtask

  initial begin
    int unsigned random_from;
    int unsigned episodes;
    int unsigned lo;
    int unsigned hi;
    int unsigned lim;
    int unsigned w;
    int unsigned h;
    int unsigned st;
    int unsigned et;
    logic [7:0]  tpu;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // stored distances read zero after reset
    for (int i = 0; i < NUM_SENSORS; i++) begin
      push_tick(1'b0, 2'(i), 4'h0);
      push_tick(1'b0, 2'(i), 4'hF);
    end
    // reset timing: long trigger low, then shortened by a retime mid-pulse
    queue_partial(2'd3, 30);
    drain();
    write_timing(8'd1, 16'd1, 16'd65535);
    settle();

    queue_measurement(2'd0, 0, uerm_pkg::RANGE_LO_MULT);
    queue_measurement(2'd1, 0, uerm_pkg::RANGE_LO_MULT - 1);
    queue_measurement(2'd1, 2, 5);
    queue_measurement(2'd0, 1, 160);
    for (int i = 0; i < NUM_SENSORS; i++)
      push_tick(1'b0, 2'(i), 4'($urandom_range(15)));

    // zero ticks per microsecond: one-tick pulses, every measurement fails
    set_timing(8'd0, 16'd65535, 16'd1);
    queue_measurement(2'd2, 0, 1);
    queue_measurement(2'd1, 3, 4);
    queue_measurement(2'd3, 0, 3);

    // widest timing limits, cut short by a retime
    set_timing(8'd255, 16'd65535, 16'd65535);
    queue_partial(2'd1, 20);
    drain();
    write_timing(8'd1, 16'd3, 16'd116);
    settle();

    // range floor meets echo timeout, start timeout edge
    queue_measurement(2'd0, 3, uerm_pkg::RANGE_LO_MULT);
    queue_measurement(2'd3, 4, 1);
    queue_measurement(2'd2, 0, uerm_pkg::RANGE_LO_MULT + 1);

    random_from = ticks_queued;
    episodes = 0;
    while (ticks_queued - random_from < RANDOM_TICKS || episodes < MIN_EPISODES) begin
      if (episodes % 3 == 0) begin
        case ($urandom_range(4))
          0:       tpu = 8'd0;
          1, 2:    tpu = 8'd1;
          3:       tpu = 8'd2;
          default: tpu = 8'd3;
        endcase
        st = ($urandom_range(1) != 0) ? $urandom_range(1, 8) : $urandom_range(1, 65535);
        case ($urandom_range(3))
          0:       et = $urandom_range(1, 10);
          1:       et = $urandom_range(1, 65535);
          default: et = $urandom_range(116, 180);
        endcase
        set_timing(tpu, 16'(st), 16'(et));
      end
      steady = (episodes >= 2 && episodes < 5);
      lo = uerm_pkg::RANGE_LO_MULT * tpu_r;
      hi = echo_to_r * tpu_r;
      if (hi > uerm_pkg::RANGE_HI_MULT * tpu_r) hi = uerm_pkg::RANGE_HI_MULT * tpu_r;
      w = $urandom_range(6);
      case ($urandom_range(9))
        0, 1, 2, 3: h = lo + $urandom_range(30);
        4:          h = (hi <= lo + 200) ? hi + $urandom_range(1) : lo;
        5, 6:       h = $urandom_range(1, (lo > 1) ? lo - 1 : 1);
        7, 8: begin
          lim = start_to_r * tpu_r;
          if (lim <= 40) w = lim + $urandom_range(2);
          h = $urandom_range(1, 20);
        end
        default:    h = 0;
      endcase
      if (h == 0) begin
        repeat ($urandom_range(5, 20))
          push_tick(1'b0, 2'($urandom_range(3)), 4'($urandom_range(15)));
      end else begin
        queue_measurement(2'($urandom_range(3)), w, h);
      end
      episodes++;
    end
    steady = 1'b0;

    while (readings_seen < ticks_queued) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && predicted.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/uerm_pkg.sv
hw/rtl/ultrasonic_echo_range_meter.sv
tb/tb_ultrasonic_echo_range_meter.sv
